// File: design/pixel_channel_integral_image_assert.svh
// assertion macros used by the checker file
`ifndef PIXEL_CHANNEL_INTEGRAL_IMAGE_ASSERT_SVH
`define PIXEL_CHANNEL_INTEGRAL_IMAGE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define PCII_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define PCII_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pcii_pkg.sv
package pcii_pkg;

  localparam int VALUE_W   = 16;
  localparam int SUM_W     = 36;
  localparam int IDX_OUT_W = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // channel modes, the unused code falls back to intensity
  localparam logic [MODE_W-1:0] MODE_INTENSITY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEPTH     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHROMA    = 2'd2;

  localparam logic [CFG_W-1:0]   WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0]   HEIGHT_RESET = 11'd480;
  localparam logic [VALUE_W-1:0] DEPTH_START  = 16'd1000;

  typedef struct packed {
    logic top_row;
    logic first_col;
    logic frame_end;
  } item_flags_t;

endpackage

// File: design/pixel_channel_integral_image.sv
// summed-area table over one channel of an rgb-d pixel stream
//
// input side is a queue: drive the pixel fields with push high, the item is
// taken at a clock edge where full is low. pixels come in raster order.
// result side is a queue: while empty is low the oldest result is on
// integral_sum, column, row and frame_end; pop high takes it.
// configuration: cfg_write_en, cfg_index and cfg_data write channel_mode,
// image_width or image_height; the user must write only while the block is idle, the block does not enforce it.
// a taken item goes through the mid queue, the back end's b2 register and the
// result queue; while nothing stalls the block takes one item per cycle, set by the single
// line buffer write and read in each cycle of the back end.
// a 4-entry queue sits between the front (channel select, counters) and the
// back (row sum, line buffer); the results go through a 2-entry queue, so
// a stalled receiver first fills those and then raises full.
// reset: mode intensity, 640 x 480, counters zero, held depth 1000, queues
// empty. the line buffer is not swept: a fill mark makes entries never
// written read as zero, so items are taken right after reset.
module pixel_channel_integral_image #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write_en,
  input  logic [pcii_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pcii_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   push,
  output logic                                   full,
  input  logic [7:0]                             red,
  input  logic [7:0]                             green,
  input  logic [7:0]                             blue,
  input  logic [15:0]                            depth_mm,
  input  logic                                   depth_valid,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [pcii_pkg::SUM_W-1:0]             integral_sum,
  output logic [pcii_pkg::IDX_OUT_W-1:0]         column,
  output logic [pcii_pkg::IDX_OUT_W-1:0]         row,
  output logic                                   frame_end
);

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int FLAGS_W   = $bits(pcii_pkg::item_flags_t);
  localparam int ITEM_W    = pcii_pkg::VALUE_W + COL_W + ROW_W + FLAGS_W;
  localparam int RESULT_W  = pcii_pkg::SUM_W + COL_W + ROW_W + 1;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // front to mid queue
  logic                         f_push;
  logic [pcii_pkg::VALUE_W-1:0] f_value;
  logic [COL_W-1:0]             f_col;
  logic [ROW_W-1:0]             f_row;
  pcii_pkg::item_flags_t        f_flags;

  // mid queue to back
  logic                         q_empty;
  logic                         q_pop;
  logic [ITEM_W-1:0]            q_data;
  logic [pcii_pkg::VALUE_W-1:0] q_value;
  logic [COL_W-1:0]             q_col;
  logic [ROW_W-1:0]             q_row;
  pcii_pkg::item_flags_t        q_flags;

  // back to result queue
  logic                         r_full;
  logic                         r_push;
  logic [pcii_pkg::SUM_W-1:0]   r_sum;
  logic [COL_W-1:0]             r_col;
  logic [ROW_W-1:0]             r_row;
  logic                         r_frame_end;
  logic [RESULT_W-1:0]          o_data;
  logic [COL_W-1:0]             o_col;
  logic [ROW_W-1:0]             o_row;

  pcii_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .depth_mm     (depth_mm),
    .depth_valid  (depth_valid),
    .q_full       (full),
    .item_push    (f_push),
    .item_value   (f_value),
    .item_col     (f_col),
    .item_row     (f_row),
    .item_flags   (f_flags)
  );

  pcii_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .data_in  ({f_value, f_col, f_row, f_flags}),
    .full     (full),
    .pop      (q_pop),
    .data_out (q_data),
    .empty    (q_empty)
  );

  assign {q_value, q_col, q_row, q_flags} = q_data;

  pcii_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .in_value    (q_value),
    .in_col      (q_col),
    .in_row      (q_row),
    .in_flags    (q_flags),
    .r_full      (r_full),
    .r_push      (r_push),
    .r_sum       (r_sum),
    .r_col       (r_col),
    .r_row       (r_row),
    .r_frame_end (r_frame_end)
  );

  pcii_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (r_push),
    .data_in  ({r_sum, r_col, r_row, r_frame_end}),
    .full     (r_full),
    .pop      (pop),
    .data_out (o_data),
    .empty    (empty)
  );

  // indices leave the block at ten bits
  assign {integral_sum, o_col, o_row, frame_end} = o_data;
  assign column = pcii_pkg::IDX_OUT_W'(o_col);
  assign row    = pcii_pkg::IDX_OUT_W'(o_row);

endmodule

// File: design/pcii_ram.sv
module pcii_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pcii_fifo.sv
module pcii_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: begin
          count <= count + 1'b1;
        end
        2'b01: begin
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

// File: design/pcii_front.sv
module pcii_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [pcii_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcii_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  push,
  input  logic [7:0]                            red,
  input  logic [7:0]                            green,
  input  logic [7:0]                            blue,
  input  logic [15:0]                           depth_mm,
  input  logic                                  depth_valid,
  input  logic                                  q_full,
  output logic                                  item_push,
  output logic [pcii_pkg::VALUE_W-1:0]          item_value,
  output logic [$clog2(MAX_WIDTH)-1:0]          item_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]         item_row,
  output pcii_pkg::item_flags_t                 item_flags
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [pcii_pkg::MODE_W-1:0]  mode;
  logic [COL_W-1:0]             width_last;
  logic [ROW_W-1:0]             height_last;
  logic [pcii_pkg::VALUE_W-1:0] held_depth;
  logic [COL_W-1:0]             col_count;
  logic [ROW_W-1:0]             row_count;

  logic                         accept;
  logic                         row_end;
  logic                         frame_end;
  logic [7:0]                   max_rg;
  logic [7:0]                   min_rg;
  logic [7:0]                   max_rgb;
  logic [7:0]                   min_rgb;
  logic [7:0]                   chroma;
  logic [9:0]                   intensity;
  logic [pcii_pkg::VALUE_W-1:0] depth_now;
  logic [pcii_pkg::VALUE_W-1:0] value;

  // last index of a size register, zero acts as one, oversize acts as max
  function automatic int size_last(input logic [pcii_pkg::CFG_W-1:0] v, input int maxv);
    if (v == '0) begin
      return 0;
    end
    if (int'(v) > maxv) begin
      return maxv - 1;
    end
    return int'(v) - 1;
  endfunction

  assign accept    = push && !q_full;
  assign row_end   = (col_count >= width_last);
  assign frame_end = row_end && (row_count >= height_last);

  assign max_rg    = (red > green) ? red : green;
  assign min_rg    = (red < green) ? red : green;
  assign max_rgb   = (max_rg > blue) ? max_rg : blue;
  assign min_rgb   = (min_rg < blue) ? min_rg : blue;
  assign chroma    = max_rgb - min_rgb;
  assign intensity = {2'b00, red} + {2'b00, green} + {2'b00, blue};
  assign depth_now = depth_valid ? depth_mm : held_depth;

  always_comb begin
    case (mode)
      pcii_pkg::MODE_DEPTH: begin
        value = depth_now;
      end
      pcii_pkg::MODE_CHROMA: begin
        value = pcii_pkg::VALUE_W'(chroma);
      end
      default: begin
        value = pcii_pkg::VALUE_W'(intensity);
      end
    endcase
  end

  assign item_push            = accept;
  assign item_value           = value;
  assign item_col             = col_count;
  assign item_row             = row_count;
  assign item_flags.top_row   = (row_count == '0);
  assign item_flags.first_col = (col_count == '0);
  assign item_flags.frame_end = frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= pcii_pkg::MODE_INTENSITY;
      width_last  <= COL_W'(size_last(pcii_pkg::WIDTH_RESET, MAX_WIDTH));
      height_last <= ROW_W'(size_last(pcii_pkg::HEIGHT_RESET, MAX_HEIGHT));
      held_depth  <= pcii_pkg::DEPTH_START;
      col_count   <= '0;
      row_count   <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          pcii_pkg::REG_CHANNEL_MODE: begin
            mode <= cfg_data[pcii_pkg::MODE_W-1:0];
          end
          pcii_pkg::REG_IMAGE_WIDTH: begin
            width_last <= COL_W'(size_last(cfg_data, MAX_WIDTH));
          end
          pcii_pkg::REG_IMAGE_HEIGHT: begin
            height_last <= ROW_W'(size_last(cfg_data, MAX_HEIGHT));
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        // depth is tracked in every mode
        held_depth <= frame_end ? pcii_pkg::DEPTH_START : depth_now;
        if (row_end) begin
          col_count <= '0;
          row_count <= frame_end ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
    end
  end

endmodule

// File: design/pcii_back.sv
module pcii_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  input  logic [pcii_pkg::VALUE_W-1:0]          in_value,
  input  logic [$clog2(MAX_WIDTH)-1:0]          in_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         in_row,
  input  pcii_pkg::item_flags_t                 in_flags,
  input  logic                                  r_full,
  output logic                                  r_push,
  output logic [pcii_pkg::SUM_W-1:0]            r_sum,
  output logic [$clog2(MAX_WIDTH)-1:0]          r_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]         r_row,
  output logic                                  r_frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int RUN_W = pcii_pkg::VALUE_W + COL_W;

  logic                         b2_valid;
  logic [pcii_pkg::VALUE_W-1:0] b2_value;
  logic [COL_W-1:0]             b2_col;
  logic [ROW_W-1:0]             b2_row;
  pcii_pkg::item_flags_t        b2_flags;
  logic                         b2_bypass;
  logic                         b2_fill_zero;
  logic [RUN_W-1:0]             run_sum;
  logic [pcii_pkg::SUM_W-1:0]   last_sum;
  logic [COL_W:0]               fill;

  logic                         b2_adv;
  logic [RUN_W-1:0]             run_new;
  logic [pcii_pkg::SUM_W-1:0]   above;
  logic [pcii_pkg::SUM_W-1:0]   rdata;
  logic [pcii_pkg::SUM_W-1:0]   sum;

  assign b2_adv = b2_valid && !r_full;
  assign q_pop  = !q_empty && (!b2_valid || b2_adv);

  // line buffer of the previous row's entries
  pcii_ram #(
    .WIDTH (pcii_pkg::SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (b2_adv),
    .waddr (b2_col),
    .wdata (sum),
    .re    (q_pop),
    .raddr (in_col),
    .rdata (rdata)
  );

  assign run_new = b2_flags.first_col ? RUN_W'(b2_value) : run_sum + RUN_W'(b2_value);

  always_comb begin
    if (b2_flags.top_row) begin
      above = '0;
    end else if (b2_bypass) begin
      above = last_sum;
    end else if (b2_fill_zero) begin
      above = '0;
    end else begin
      above = rdata;
    end
  end

  assign sum         = pcii_pkg::SUM_W'(run_new) + above;
  assign r_push      = b2_adv;
  assign r_sum       = sum;
  assign r_col       = b2_col;
  assign r_row       = b2_row;
  assign r_frame_end = b2_flags.frame_end;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_value     <= in_value;
      b2_col       <= in_col;
      b2_row       <= in_row;
      b2_flags     <= in_flags;
      // previous item writes the same entry in this cycle
      b2_bypass    <= b2_valid && (b2_col == in_col);
      // entries past the written prefix were never written; they read as zero
      b2_fill_zero <= ({1'b0, in_col} >= fill);
    end
    if (b2_adv) begin
      run_sum  <= run_new;
      last_sum <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
      fill     <= '0;
    end else begin
      if (q_pop) begin
        b2_valid <= 1'b1;
      end else if (b2_adv) begin
        b2_valid <= 1'b0;
      end
      if (b2_adv && ({1'b0, b2_col} == fill)) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

// File: design/pcii_checker.sv
`include "pixel_channel_integral_image_assert.svh"

module pcii_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  full,
  input logic                                  empty,
  input logic                                  pop,
  input logic [pcii_pkg::SUM_W-1:0]            integral_sum,
  input logic [pcii_pkg::IDX_OUT_W-1:0]        column,
  input logic [pcii_pkg::IDX_OUT_W-1:0]        row,
  input logic                                  frame_end
);

  // the result queue comes out of reset empty and the input side not full
  `PCII_ASSERT_IMPLY(a_reset_empty, clk, rst, $fell(rst), empty && !full, "queues not empty after reset")

  // a waiting result holds until taken
  `PCII_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(integral_sum) && $stable(column) && $stable(row) && $stable(frame_end), "result changed while waiting")

  // the next result either starts a row or is the next column of the same row
  `PCII_ASSERT_NEXT(a_raster_order, clk, rst, !empty && pop, empty || (column == 10'd0) || ((column == $past(column) + 10'd1) && (row == $past(row))), "results out of raster order")

  // the frame origin holds a single channel value
  `PCII_ASSERT_IMPLY(a_origin_bound, clk, rst, !empty && (row == 10'd0) && (column == 10'd0), integral_sum <= 36'd65535, "origin entry too large")

endmodule

bind pixel_channel_integral_image pcii_checker u_checker (.*);

// File: tb/pixel_channel_integral_image_check.sv
`timescale 1ns / 1ps

module pixel_channel_integral_image_check #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [pcii_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcii_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           push,
  input  logic                           full,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [15:0]                    depth_mm,
  input  logic                           depth_valid,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [pcii_pkg::SUM_W-1:0]     integral_sum,
  input  logic [pcii_pkg::IDX_OUT_W-1:0] column,
  input  logic [pcii_pkg::IDX_OUT_W-1:0] row,
  input  logic                           frame_end,
  output int                             mismatches,
  output int                             pending
);
  import pcii_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [IDX_OUT_W-1:0] column;
    logic [IDX_OUT_W-1:0] row;
    logic                 frame_end;
  } sat_entry_t;

  sat_entry_t           sat_queue[$];
  logic [SUM_W-1:0]     line_sums[MAX_WIDTH];
  logic [63:0]          row_acc;
  logic [VALUE_W-1:0]   depth_hold;
  logic [IDX_OUT_W-1:0] col_pos;
  logic [IDX_OUT_W-1:0] row_pos;
  logic [MODE_W-1:0]    mode_reg;
  logic [CFG_W-1:0]     width_reg;
  logic [CFG_W-1:0]     height_reg;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return v;
  endfunction

  // one step of the summed-area table: updates the shadow state
  function automatic sat_entry_t predict_pixel(input logic [7:0] r, g, b,
                                               input logic [15:0] d, input logic dv);
    sat_entry_t  e;
    int unsigned w, h, hi, lo, v;
    logic [SUM_W-1:0] above;
    logic        row_done, frame_done;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (dv) depth_hold = d;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    case (mode_reg)
      MODE_DEPTH:  v = depth_hold;
      MODE_CHROMA: v = hi - lo;
      default:     v = r + g + b;
    endcase
    if (col_pos == '0) row_acc = '0;
    row_acc = row_acc + v;
    above = (row_pos == '0) ? '0 : line_sums[col_pos];
    e.sum = SUM_W'(row_acc + above);
    line_sums[col_pos] = e.sum;
    row_done   = int'(col_pos) >= int'(w) - 1;
    frame_done = row_done && (int'(row_pos) >= int'(h) - 1);
    e.column    = col_pos;
    e.row       = row_pos;
    e.frame_end = frame_done;
    if (frame_done) begin
      col_pos    = '0;
      row_pos    = '0;
      depth_hold = DEPTH_START;
      row_acc    = '0;
    end else if (row_done) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
      row_acc = '0;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    sat_entry_t got, want;
    if (rst) begin
      sat_queue.delete();
      for (int i = 0; i < MAX_WIDTH; i++) line_sums[i] = '0;
      row_acc    = '0;
      depth_hold = DEPTH_START;
      col_pos    = '0;
      row_pos    = '0;
      mode_reg   = MODE_INTENSITY;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mismatches = 0;
    end else begin
      if (pop && !empty) begin
        got = '{integral_sum, column, row, frame_end};
        if (sat_queue.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result sum=%h col=%0d row=%0d end=%b",
                     $realtime, got.sum, got.column, got.row, got.frame_end);
          mismatches++;
        end else begin
          want = sat_queue.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: exp sum=%h col=%0d row=%0d end=%b, got sum=%h col=%0d row=%0d end=%b",
                       $realtime, want.sum, want.column, want.row, want.frame_end,
                       got.sum, got.column, got.row, got.frame_end);
            mismatches++;
          end
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          REG_CHANNEL_MODE: mode_reg   = cfg_data[MODE_W-1:0];
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        sat_queue.push_back(predict_pixel(red, green, blue, depth_mm, depth_valid));
    end
    pending = sat_queue.size();
  end

endmodule

// File: tb/pixel_channel_integral_image_test.sv
`timescale 1ns / 1ps

module pixel_channel_integral_image_test;
  import pcii_pkg::*;

  // the one mode code the package leaves unnamed, it should act as intensity
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 100;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_CHANNEL_MODE;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 push         = 1'b0;
  logic [7:0]           red          = '0;
  logic [7:0]           green        = '0;
  logic [7:0]           blue         = '0;
  logic [15:0]          depth_mm     = '0;
  logic                 depth_valid  = 1'b0;
  logic                 pop          = 1'b0;
  logic                 full;
  logic                 empty;
  logic [SUM_W-1:0]     integral_sum;
  logic [IDX_OUT_W-1:0] column;
  logic [IDX_OUT_W-1:0] row;
  logic                 frame_end;
  int                   mismatches;
  int                   pending;

  // set for the closing stretch: no gaps on the pixel side, no stalls on the result side
  bit calm = 1'b0;
  int random_sent = 0;

  pixel_channel_integral_image u_dut (.*);

  pixel_channel_integral_image_check u_check (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case a handshake hangs
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: pop mostly high, with random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  // offer one pixel item and return at the edge that takes it
  task automatic send_pixel(input logic [7:0] r, g, b, input logic [15:0] d,
                            input logic dv);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push        <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    depth_mm    <= d;
    depth_valid <= dv;
    do @(posedge clk); while (full);
  endtask

  // random pixel, now and then with every component pinned at an extreme
  task automatic send_random_pixel(input int valid_pct);
    logic [7:0]  r, g, b;
    logic [15:0] d;
    logic        dv;
    r  = 8'($urandom);
    g  = 8'($urandom);
    b  = 8'($urandom);
    d  = 16'($urandom);
    dv = $urandom_range(0, 99) < valid_pct;
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, 1) ? 8'hff : 8'h00;
      g = $urandom_range(0, 1) ? 8'hff : 8'h00;
      b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      d = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    end
    send_pixel(r, g, b, d, dv);
  endtask

  // drop push and wait for the block to drain; every item gives a result,
  // so waiting until no result is pending covers the pipeline
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // all three registers, one write per cycle, only while idle
  task automatic configure(input logic [MODE_W-1:0] mode, input logic [CFG_W-1:0] w, h);
    settle();
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_CHANNEL_MODE;
    cfg_data     <= CFG_W'(mode);
    @(posedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > 11'd1024) return 1024;
    return v;
  endfunction

  // frame sizes: mostly small, sometimes zero, one, medium or past the maximum
  function automatic logic [CFG_W-1:0] pick_dim();
    int k;
    logic [CFG_W-1:0] v;
    k = $urandom_range(0, 15);
    if (k == 0)      v = '0;
    else if (k == 1) v = 11'd1;
    else if (k == 2) v = CFG_W'($urandom_range(1025, 2047));
    else if (k <= 4) v = CFG_W'($urandom_range(13, 40));
    else             v = CFG_W'($urandom_range(2, 12));
    return v;
  endfunction

  // one random phase: new settings, then whole frames plus a ragged tail,
  // so the next phase often starts mid-row or mid-frame
  task automatic random_phase();
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  w, h;
    int n, valid_pct;
    mode = MODE_W'($urandom_range(0, 3));
    w    = pick_dim();
    h    = pick_dim();
    n    = eff_dim(w) * eff_dim(h) * $urandom_range(1, 2) + $urandom_range(0, 3);
    if (n > 150) n = $urandom_range(20, 150);
    valid_pct = $urandom_range(0, 4) * 25;
    configure(mode, w, h);
    repeat (n) begin
      send_random_pixel(valid_pct);
      random_sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 640 wide, intensity
    send_pixel(8'd1, 8'd2, 8'd3, 16'd0, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 16'hffff, 1'b0);

    // intensity over a 3 x 2 frame, extremes of the colour components
    configure(MODE_INTENSITY, 11'd3, 11'd2);
    send_pixel(8'h00, 8'h00, 8'h00, 16'h0000, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 16'hffff, 1'b1);
    send_pixel(8'hff, 8'h00, 8'h00, 16'h0000, 1'b1);
    send_pixel(8'h00, 8'hff, 8'h00, 16'h1234, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hff, 16'h0000, 1'b0);
    send_pixel(8'haa, 8'h55, 8'h33, 16'h8001, 1'b1);
    // first pixel of the next frame, line buffer above must count as zero
    send_pixel(8'h10, 8'h20, 8'h30, 16'h0000, 1'b0);

    // chroma on a 2 x 2 frame; a valid depth here is still tracked
    configure(MODE_CHROMA, 11'd2, 11'd2);
    send_pixel(8'hff, 8'h00, 8'h80, 16'h0000, 1'b0);
    send_pixel(8'h07, 8'h07, 8'h07, 16'd300, 1'b1);
    send_pixel(8'h01, 8'hc8, 8'h64, 16'h0000, 1'b0);
    // switch to depth mid-frame: missing depth reuses the held 300
    configure(MODE_DEPTH, 11'd2, 11'd2);
    send_pixel(8'h00, 8'h00, 8'h00, 16'hffff, 1'b0);
    // held depth back at 1000 after that frame end, then valid extremes
    configure(MODE_DEPTH, 11'd4, 11'd1);
    send_pixel(8'h00, 8'h00, 8'h00, 16'h0005, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 16'hffff, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 16'h0005, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 16'h0000, 1'b1);

    // unused mode code, zero sizes act as 1 x 1
    configure(MODE_UNUSED, 11'd0, 11'd0);
    send_pixel(8'hff, 8'h01, 8'h02, 16'h0000, 1'b0);
    send_pixel(8'h80, 8'h40, 8'h20, 16'h0000, 1'b0);

    // shrinking the width mid-row ends the row at once
    configure(MODE_INTENSITY, 11'd8, 11'd4);
    send_pixel(8'h01, 8'h01, 8'h01, 16'h0000, 1'b0);
    send_pixel(8'h02, 8'h02, 8'h02, 16'h0000, 1'b0);
    send_pixel(8'h03, 8'h03, 8'h03, 16'h0000, 1'b0);
    configure(MODE_INTENSITY, 11'd2, 11'd4);
    send_pixel(8'h04, 8'h04, 8'h04, 16'h0000, 1'b0);
    send_pixel(8'h05, 8'h05, 8'h05, 16'h0000, 1'b0);
    // sizes past the maximum
    configure(MODE_CHROMA, 11'd2047, 11'd2047);
    send_pixel(8'h00, 8'hff, 8'h00, 16'h0000, 1'b0);
    send_pixel(8'hff, 8'h00, 8'hff, 16'h0000, 1'b1);

    // random phases, each waits for the block to drain before new settings
    while (random_sent < RANDOM_ITEMS) random_phase();

    // tallest frame: one column, clamped height, runs past row 1023
    configure(MODE_DEPTH, 11'd1, 11'd2047);
    repeat (1026) send_random_pixel(30);

    // closing stretch without random gaps or stalls
    calm = 1'b1;
    configure(MODE_CHROMA, 11'd5, 11'd3);
    repeat (40) send_random_pixel(50);
    configure(MODE_DEPTH, 11'd1024, 11'd1024);
    repeat (20) send_random_pixel(50);

    settle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
